@@ hw/rtl/ffba_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and handshake bundles of the first-fit block allocator.
package ffba_pkg;

  localparam int HEAP_BYTES_C   = 4096;
  localparam int HEADER_BYTES_C = 8;
  localparam int ALIGN_BYTES_C  = 4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] request_size;
    logic [11:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [11:0] result_address;
    logic        success;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scale;
    logic walk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

endpackage

@@ hw/rtl/ffba_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences sizing, the header walk and result transfer.
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffba_pkg::status_t  status,
  output ffba_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_WALK,
    ST_RESULT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.div_step = (state_r == ST_DIV);
    cmd.scale    = (state_r == ST_SCALE);
    cmd.walk     = (state_r == ST_WALK);
    cmd.out_load = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= (in_kind == ffba_pkg::KIND_ALLOC) ? ST_DIV : ST_WALK;
          end
        end
        ST_DIV: begin
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          if (status.walk_done) begin
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (cmd.out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ffba_dp.sv @@
`timescale 1ns / 1ps
// Datapath with the header memory, size rounding multiplier, walk pointers and result registers.
module ffba_dp #(
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_C,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_C,
  parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_C
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::cmd_t      cmd,
  input  ffba_pkg::in_item_t  in_item,
  output ffba_pkg::status_t   status,
  output ffba_pkg::out_item_t out_item
);

  localparam int ADDR_W   = $clog2(HEAP_BYTES + 1);
  localparam int SZ_W     = ((ADDR_W > 13) ? ADDR_W : 13) + 1;
  localparam int SLOTS    = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW       = $clog2(SLOTS + 1);
  localparam int PROD_W   = 2 * SZ_W + 1;
  localparam int RECIP_SH = SZ_W + $clog2(ALIGN_BYTES);
  localparam int RECIP_M  = ((1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

  localparam logic [SZ_W-1:0]   HDR_C   = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]   ROUND_C = SZ_W'(HEADER_BYTES + ALIGN_BYTES - 1);
  localparam logic [SZ_W-1:0]   ALIGN_C = SZ_W'(ALIGN_BYTES);
  localparam logic [SZ_W:0]     HEAP_C  = (SZ_W + 1)'(HEAP_BYTES);
  localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP_M);

  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] bytes;
    logic [UW-1:0]     units;
  } hdr_t;

  hdr_t mem [SLOTS];
  hdr_t rd_r;

  ffba_pkg::in_item_t  item_r;
  ffba_pkg::out_item_t res_r;
  ffba_pkg::out_item_t out_r;

  logic [SZ_W-1:0] quo_r;
  logic [SZ_W-1:0] need_bytes_r;
  logic [UW-1:0]   need_units_r;
  logic [SZ_W-1:0] cur_bytes_r;
  logic [UW-1:0]   cur_units_r;
  logic [SZ_W-1:0] brk_bytes_r;
  logic [UW-1:0]   brk_units_r;

  logic [PROD_W-1:0] recip_prod;
  logic [SZ_W-1:0] target;
  logic            bad_addr;
  logic            is_alloc;
  logic            at_end;
  logic            size_zero;
  logic            hit_fit;
  logic            hit_tgt;
  logic            past_tgt;
  logic [SZ_W:0]   brk_sum;
  logic            fits;
  logic            done;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  hdr_t            wr_data;
  logic            brk_adv;
  ffba_pkg::out_item_t res_nxt;

  // The reciprocal is rounded up, which makes the quotient exact over the whole size range.
  assign recip_prod = PROD_W'(quo_r) * RECIP_C;

  assign is_alloc  = (item_r.kind == ffba_pkg::KIND_ALLOC);
  assign bad_addr  = (SZ_W'(item_r.block_address) < HDR_C);
  assign target    = SZ_W'(item_r.block_address) - HDR_C;
  assign at_end    = (cur_bytes_r >= brk_bytes_r);
  assign size_zero = (rd_r.bytes == '0);
  assign hit_fit   = !at_end && rd_r.free && (SZ_W'(rd_r.bytes) >= need_bytes_r);
  assign hit_tgt   = !at_end && (cur_bytes_r == target);
  assign past_tgt  = (cur_bytes_r > target);
  assign brk_sum   = (SZ_W + 1)'(brk_bytes_r) + (SZ_W + 1)'(need_bytes_r);
  assign fits      = (brk_sum <= HEAP_C);

  always_comb begin
    if (is_alloc) begin
      done = at_end || hit_fit || size_zero;
    end else begin
      done = bad_addr || at_end || hit_tgt || past_tgt || size_zero;
    end
  end

  always_comb begin
    if (cmd.walk && !done) begin
      rd_addr = IW'(cur_units_r + rd_r.units);
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = IW'(cur_units_r);
    wr_data = rd_r;
    brk_adv = 1'b0;
    res_nxt = '0;
    if (cmd.walk && done) begin
      if (is_alloc) begin
        if (hit_fit) begin
          wr_en                  = 1'b1;
          wr_data.free           = 1'b0;
          res_nxt.result_address = 12'(cur_bytes_r + HDR_C);
          res_nxt.success        = 1'b1;
        end else if (fits) begin
          wr_en                  = 1'b1;
          wr_idx                 = IW'(brk_units_r);
          wr_data.free           = 1'b0;
          wr_data.bytes          = ADDR_W'(need_bytes_r);
          wr_data.units          = need_units_r;
          brk_adv                = 1'b1;
          res_nxt.result_address = 12'(brk_bytes_r + HDR_C);
          res_nxt.success        = 1'b1;
        end
      end else if (!bad_addr && hit_tgt && !rd_r.free) begin
        wr_en           = 1'b1;
        wr_data.free    = 1'b1;
        res_nxt.success = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_bytes_r <= '0;
      brk_units_r <= '0;
    end else if (brk_adv) begin
      brk_bytes_r <= brk_bytes_r + need_bytes_r;
      brk_units_r <= brk_units_r + need_units_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_item;
      quo_r       <= SZ_W'(in_item.request_size) + ROUND_C;
      cur_bytes_r <= '0;
      cur_units_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= SZ_W'(recip_prod >> RECIP_SH);
    end else if (cmd.walk && !done) begin
      cur_bytes_r <= cur_bytes_r + SZ_W'(rd_r.bytes);
      cur_units_r <= cur_units_r + rd_r.units;
    end
    if (cmd.scale) begin
      need_bytes_r <= SZ_W'(quo_r * ALIGN_C);
      need_units_r <= UW'(quo_r);
    end
    if (cmd.walk && done) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign status.walk_done = cmd.walk && done;
  assign out_item         = out_r;

endmodule

@@ hw/rtl/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the first-fit block allocator, joining controller and datapath.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall   ffba_pkg::in_item_t
//   out      output     out_valid / out_stall ffba_pkg::out_item_t
//
// An allocate rounds its size in the divide and scale states; a free goes straight to the walk.
// The walk steps past one header at a time until it stops, and the result state then loads
// the output register, holding off while a stalled result is still pending there.
// Reset empties the heap at once; the header memory needs no clearing pass.
// A finished result waits in the output register while the next transfer is taken in.
module first_fit_block_allocator #(
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_C,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_C,
  parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_C
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_item_t out_item
);

  ffba_pkg::cmd_t    cmd;
  ffba_pkg::status_t status;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_item.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ffba_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

endmodule

@@ hw/rtl/ffba_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the first-fit block allocator and its bind statement.
module ffba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ffba_pkg::out_item_t out_item
);

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The block works on one item at a time, so it is busy right after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  // A refused request never reports an address.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.success |-> out_item.result_address == 12'd0)
    else $error("failed request carries an address");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
